// File: hw/rtl/window_mean_edge_mark_assert.svh
// Assertion macros for the 3x3 window mean and edge mark block.
// Used by window_mean_edge_mark.sv; no other dependencies.
`ifndef WINDOW_MEAN_EDGE_MARK_ASSERT_SVH
`define WINDOW_MEAN_EDGE_MARK_ASSERT_SVH

`ifndef SYNTH

// Expression holds at every clock edge outside reset.
`define WMEM_ASSERT(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("window_mean_edge_mark: invariant violated");

// Antecedent implies consequent in the same cycle.
`define WMEM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("window_mean_edge_mark: implication violated");

`else

`define WMEM_ASSERT(lbl, clk, rst, expr)
`define WMEM_ASSERT_IMP(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/wmem_pkg.sv
// Package for the 3x3 window mean and edge mark block.
// Holds register indexes, field widths, reset values and shared types; no dependencies.
package wmem_pkg;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WHITE_LEVEL  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLACK_LEVEL  = 3'd3;

  // Request type codes.
  localparam logic REQ_PIXEL = 1'b0;

  // Pixel and line store word widths.
  localparam int PIX_W   = 8;
  localparam int LEVEL_W = 8;
  localparam int LINE_W  = 2 * PIX_W;

  // Register reset values.
  localparam int                 DIM_RESET   = 1024;
  localparam logic [LEVEL_W-1:0] WHITE_RESET = 8'd255;
  localparam logic [LEVEL_W-1:0] BLACK_RESET = 8'd0;

  // Window arithmetic: sum of up to nine pixels, count up to nine,
  // products of a level (plus one) and a count.
  localparam int SUM_W  = 12;
  localparam int CNT_W  = 4;
  localparam int PROD_W = 13;

  // Result queue.
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = 3;
  localparam int RES_CNT_W = 4;

  typedef logic [PIX_W-1:0] pix_t;

  // Which window borders fall outside the frame for one result.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

endpackage

// File: hw/rtl/window_mean_edge_mark.sv
// Top level of the 3x3 window mean and edge mark block.
// Depends on wmem_pkg and the assertion macros in window_mean_edge_mark_assert.svh.
//
// The block takes one grey pixel per clock while pix_stall is low, in raster order, and
// returns, for every pixel, an edge mark that is set when the floor of the mean over its 3x3
// neighborhood (only the pixels inside the frame, the center included) lies strictly between
// black_level and white_level. Results come in raster order, frame_width + 1 requests behind
// the input; after the last pixel of a frame, flush requests push out the results still
// pending, and the result of the frame's final pixel carries frame_last. The sustained rate
// is one request per clock while pix_stall is low. The edge that accepts a request starts its
// line store read; then come the window update with write back, the masked window sum, and
// the level compare that writes the queue. The line store is a single memory of MAX_WIDTH
// words with one read and one write per cycle; when the frame is one pixel wide, consecutive
// requests hit the same word and the written value is forwarded to the next read. Results
// wait in an eight entry queue, and pix_stall rises only when the queue together with the
// requests still in the pipeline could fill it, so a result waiting at the output does not
// block the input. The line store needs no clearing pass: words never written are only read
// for window positions outside the frame, which are masked. Any write to a known register
// restarts the frame; write configuration only while the block is idle.
`include "window_mean_edge_mark_assert.svh"

module window_mean_edge_mark
  import wmem_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Pixel requests
  input  logic                   pix_valid,
  output logic                   pix_stall,
  input  logic                   req_type,
  input  logic [PIX_W-1:0]       pixel,
  // Results
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic                   edge_mark,
  output logic                   frame_last
);

  // Column index, effective width, effective height and input row widths. The input row can
  // run two rows past the frame while the last results drain.
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int RST_W = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;
  localparam int RST_H = (MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET;

  // ---------------------------------------------------------------------------------------
  // Configuration. Frame sizes are stored already clamped to their legal range.
  // ---------------------------------------------------------------------------------------
  logic [WW-1:0]      w_eff;
  logic [CW-1:0]      w_last;
  logic [HW-1:0]      h_eff;
  logic [HW-1:0]      h_last;
  logic [LEVEL_W-1:0] white_level;
  logic [LEVEL_W-1:0] black_level;

  logic          cfg_we;
  logic          cfg_hit;
  logic [WW-1:0] w_new;
  logic [HW-1:0] h_new;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_hit = cfg_we && (cfg_index inside {[CFG_FRAME_WIDTH:CFG_BLACK_LEVEL]});

    if (cfg_data == '0) begin
      w_new = WW'(1);
    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
      w_new = WW'(MAX_WIDTH);
    end else begin
      w_new = WW'(cfg_data);
    end

    if (cfg_data == '0) begin
      h_new = HW'(1);
    end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
      h_new = HW'(MAX_HEIGHT);
    end else begin
      h_new = HW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff       <= WW'(RST_W);
      w_last      <= CW'(RST_W - 1);
      h_eff       <= HW'(RST_H);
      h_last      <= HW'(RST_H - 1);
      white_level <= WHITE_RESET;
      black_level <= BLACK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          w_eff  <= w_new;
          w_last <= CW'(w_new - 1'b1);
        end
        CFG_FRAME_HEIGHT: begin
          h_eff  <= h_new;
          h_last <= h_new - 1'b1;
        end
        CFG_WHITE_LEVEL: begin
          white_level <= cfg_data[LEVEL_W-1:0];
        end
        CFG_BLACK_LEVEL: begin
          black_level <= cfg_data[LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Request decode and raster positions, settled in the cycle a request is accepted.
  // ---------------------------------------------------------------------------------------
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic [HW-1:0] out_row;
  logic [CW-1:0] out_col;

  logic [RW-1:0] in_row_next;
  logic [CW-1:0] in_col_next;
  logic [HW-1:0] out_row_next;
  logic [CW-1:0] out_col_next;

  logic          pix_acc;
  logic          is_pixel;
  logic          frame_done;
  logic          draining;
  logic          proc;
  logic          emit;
  logic [RW-1:0] row_e;
  logic [CW-1:0] col_e;
  logic [HW-1:0] orow_e;
  logic [CW-1:0] ocol_e;
  pix_t          pix_e;
  border_t       border_e;

  assign pix_acc = pix_valid && !pix_stall;

  always_comb begin
    is_pixel   = (req_type == REQ_PIXEL);
    frame_done = (out_row >= h_eff);

    // Once every result of a frame is out, a pixel request starts the next frame.
    row_e  = frame_done ? '0 : in_row;
    col_e  = frame_done ? '0 : in_col;
    orow_e = frame_done ? '0 : out_row;
    ocol_e = frame_done ? '0 : out_col;

    // Past the last input row every request is a flush and feeds a black pixel.
    draining = (row_e >= RW'(h_eff));
    proc     = pix_acc && (frame_done ? is_pixel : (is_pixel || draining));
    pix_e    = draining ? '0 : pixel;

    // A result is due once the window center has a full row and one pixel behind it.
    emit = (row_e > RW'(1)) || ((row_e == RW'(1)) && (col_e != '0));

    border_e.top    = (orow_e == '0);
    border_e.bottom = (orow_e == h_last);
    border_e.left   = (ocol_e == '0);
    border_e.right  = (ocol_e == w_last);

    if (col_e == w_last) begin
      in_col_next = '0;
      in_row_next = row_e + 1'b1;
    end else begin
      in_col_next = col_e + 1'b1;
      in_row_next = row_e;
    end

    if (!emit) begin
      out_col_next = ocol_e;
      out_row_next = orow_e;
    end else if (ocol_e == w_last) begin
      out_col_next = '0;
      out_row_next = orow_e + 1'b1;
    end else begin
      out_col_next = ocol_e + 1'b1;
      out_row_next = orow_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (proc) begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: line store read. Each word holds the two previous rows of its column, the older
  // row in the upper byte. The write back of the previous request is forwarded when it hits
  // the word read in the same cycle.
  // ---------------------------------------------------------------------------------------
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] mem_q;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;
  logic [LINE_W-1:0] byp_data;
  logic              byp_hit;

  logic              s1_valid;
  logic              s1_emit;
  logic [CW-1:0]     s1_col;
  pix_t              s1_pix;
  border_t           s1_border;
  logic              s1_last;

  assign line_rd = byp_hit ? byp_data : mem_q;
  assign line_wr = {line_rd[PIX_W-1:0], s1_pix};

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_col] <= line_wr;
    end
    if (proc) begin
      mem_q <= line_mem[col_e];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      s1_valid <= proc;
      s1_emit  <= emit;
    end
    byp_hit   <= s1_valid && (s1_col == col_e);
    byp_data  <= line_wr;
    s1_col    <= col_e;
    s1_pix    <= pix_e;
    s1_border <= border_e;
    s1_last   <= border_e.bottom && border_e.right;
  end

  // ---------------------------------------------------------------------------------------
  // Window shift. Column 2 is the newest; row 2 is the current input row.
  // ---------------------------------------------------------------------------------------
  pix_t win [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]     <= win[r*3 + 1];
        win[r*3 + 1] <= win[r*3 + 2];
      end
      win[2] <= line_rd[LINE_W-1:PIX_W];
      win[5] <= line_rd[PIX_W-1:0];
      win[8] <= s1_pix;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: masked window sum and pixel count.
  // ---------------------------------------------------------------------------------------
  logic              s2_valid;
  border_t           s2_border;
  logic              s2_last;
  logic [SUM_W-1:0]  sum_c;
  logic [CNT_W-1:0]  cnt_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
    s2_border <= s1_border;
    s2_last   <= s1_last;
  end

  always_comb begin
    logic keep;
    sum_c = '0;
    cnt_c = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        keep = !((r == 0) && s2_border.top) && !((r == 2) && s2_border.bottom) &&
               !((c == 0) && s2_border.left) && !((c == 2) && s2_border.right);
        if (keep) begin
          sum_c = sum_c + SUM_W'(win[r*3 + c]);
          cnt_c = cnt_c + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: the mean is compared without division, as sum against level times count.
  // ---------------------------------------------------------------------------------------
  logic              s3_valid;
  logic [SUM_W-1:0]  s3_sum;
  logic [CNT_W-1:0]  s3_cnt;
  logic              s3_last;
  logic [PROD_W-1:0] lo_bound;
  logic [PROD_W-1:0] hi_bound;
  logic              mark_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_sum  <= sum_c;
    s3_cnt  <= cnt_c;
    s3_last <= s2_last;
  end

  always_comb begin
    lo_bound = (PROD_W'(black_level) + 1'b1) * PROD_W'(s3_cnt);
    hi_bound = PROD_W'(white_level) * PROD_W'(s3_cnt);
    mark_c   = (PROD_W'(s3_sum) >= lo_bound) && (PROD_W'(s3_sum) < hi_bound);
  end

  // ---------------------------------------------------------------------------------------
  // Result queue. Input is stalled when the queue plus every result still in flight could
  // reach its depth, so nothing in the pipeline ever has to wait.
  // ---------------------------------------------------------------------------------------
  logic                 fifo_mark [RES_DEPTH];
  logic                 fifo_last [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] fifo_count;
  logic [RES_CNT_W-1:0] occupancy;
  logic                 pop;

  assign occupancy = fifo_count + RES_CNT_W'(s1_valid && s1_emit) + RES_CNT_W'(s2_valid) +
                     RES_CNT_W'(s3_valid);
  assign pix_stall  = (occupancy >= RES_CNT_W'(RES_DEPTH));
  assign res_valid  = (fifo_count != '0);
  assign edge_mark  = fifo_mark[rd_ptr];
  assign frame_last = fifo_last[rd_ptr];
  assign pop        = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (s3_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_count <= fifo_count + RES_CNT_W'(s3_valid) - RES_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      fifo_mark[wr_ptr] <= mark_c;
      fifo_last[wr_ptr] <= s3_last;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  `WMEM_ASSERT(a_credit_bound, clk, rst, occupancy <= RES_CNT_W'(RES_DEPTH))
  `WMEM_ASSERT(a_in_col_range, clk, rst, WW'(in_col) < w_eff)
  `WMEM_ASSERT(a_out_row_range, clk, rst, out_row <= h_eff)
  `WMEM_ASSERT_IMP(a_push_origin, clk, rst, s3_valid, $past(s1_valid && s1_emit, 2))

endmodule

// File: tb/tb_window_mean_edge_mark.sv
`timescale 1ns / 100ps
// Self-checking testbench for window_mean_edge_mark: directed frames, then random frames.
// Depends on wmem_pkg and the block's RTL; a scoreboard class predicts every edge mark.

module tb_window_mean_edge_mark
  import wmem_pkg::*;
;

  // The block is built at its default sizes, so the frame limits below match it.
  localparam int MAX_DIM = 1024;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  // The pipeline stages and the result queue need time to empty after the last request.
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 540;
  localparam int MAX_REPORTS   = 10;

  // The package only names the pixel code; a flush is the other value of the bit.
  localparam logic REQ_FLUSH = ~REQ_PIXEL;

  // Register indexes past the four real registers; the block ignores writes to them.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_FIRST = CFG_BLACK_LEVEL + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LAST  = '1;

  // A small frame with both pixel extremes and a value just above black.
  localparam logic [PIX_W-1:0] TILE_3X3 [9] = '{
    8'h00, 8'hFF, 8'h80,
    8'hFF, 8'hFF, 8'hFF,
    8'h01, 8'h00, 8'hC8
  };

  typedef enum {FILL_UNIFORM, FILL_EXTREMES, FILL_BAND} fill_t;

  typedef struct packed {
    logic edge_mark;
    logic frame_last;
  } mark_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } reg_write_t;

  // Scoreboard. It keeps its own copy of the registers, the line store, the 3x3 window
  // and the input and output raster positions, and queues the edge mark that every accepted
  // request should produce. Results from the block are compared against the oldest entry.
  class mean_edge_scoreboard;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [LEVEL_W-1:0]    white_reg;
    logic [LEVEL_W-1:0]    black_reg;

    // Each word holds the pixel two rows up in the high byte and one row up in the low byte.
    logic [LINE_W-1:0] line_words [MAX_DIM];
    logic [PIX_W-1:0]  window [9];
    int unsigned       in_row, in_col, out_row, out_col;

    mark_t       expected_marks [$];
    int unsigned results_seen;
    int unsigned mismatches;

    function new();
      width_reg  = CFG_DATA_W'(DIM_RESET);
      height_reg = CFG_DATA_W'(DIM_RESET);
      white_reg  = WHITE_RESET;
      black_reg  = BLACK_RESET;
      foreach (line_words[i]) line_words[i] = '0;
      foreach (window[i]) window[i] = '0;
      rewind();
    endfunction

    function void rewind();
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    // Zero behaves as one and anything above the block's limit as the limit.
    function int unsigned dim_limit(logic [CFG_DATA_W-1:0] value);
      if (value == '0) return 1;
      if (32'(value) > MAX_DIM) return MAX_DIM;
      return 32'(value);
    endfunction

    function int unsigned active_width();
      return dim_limit(width_reg);
    endfunction

    function int unsigned active_height();
      return dim_limit(height_reg);
    endfunction

    function int unsigned pending();
      return expected_marks.size();
    endfunction

    function void note_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_FRAME_WIDTH: width_reg = data;
        CFG_FRAME_HEIGHT: height_reg = data;
        CFG_WHITE_LEVEL: white_reg = data[LEVEL_W-1:0];
        CFG_BLACK_LEVEL: black_reg = data[LEVEL_W-1:0];
        default: return;
      endcase
      // Every write to a real register starts the frame over; the stores keep their data.
      rewind();
    endfunction

    function void note_request(logic kind, logic [PIX_W-1:0] value);
      int unsigned w, h, col, raster, sum, cnt;
      logic [PIX_W-1:0]  pix;
      logic [LINE_W-1:0] line_word;
      logic              is_pixel;
      mark_t             mark;

      w = active_width();
      h = active_height();
      is_pixel = (kind == REQ_PIXEL);
      pix = value;

      // Once the frame is fully out, only a pixel (the first of a new frame) does anything.
      if (out_row >= h) begin
        if (!is_pixel) return;
        rewind();
      end
      // Past the last input row every request drains; a flush before then is dropped.
      if (in_row >= h) begin
        pix = '0;
      end else if (!is_pixel) begin
        return;
      end

      col = (in_col < w) ? in_col : 0;
      line_word = line_words[col];
      for (int r = 0; r < 3; r++) begin
        window[r * 3]     = window[r * 3 + 1];
        window[r * 3 + 1] = window[r * 3 + 2];
      end
      window[2] = line_word[LINE_W-1:PIX_W];
      window[5] = line_word[PIX_W-1:0];
      window[8] = pix;
      line_words[col] = {line_word[PIX_W-1:0], pix};

      raster = in_row * w + in_col;
      if (raster >= w + 1 && out_row < h) begin
        sum = 0;
        cnt = 0;
        for (int r = 0; r < 3; r++) begin
          if (!(r == 0 && out_row == 0) && !(r == 2 && out_row == h - 1)) begin
            for (int c = 0; c < 3; c++) begin
              if (!(c == 0 && out_col == 0) && !(c == 2 && out_col == w - 1)) begin
                sum += 32'(window[r * 3 + c]);
                cnt++;
              end
            end
          end
        end
        // floor(sum / cnt) strictly between the levels, tested without a divide.
        mark.edge_mark  = (sum >= (int'(black_reg) + 1) * cnt) && (sum < int'(white_reg) * cnt);
        mark.frame_last = (out_row == h - 1) && (out_col == w - 1);
        expected_marks = {expected_marks, mark};
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end

      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void check_result(logic got_mark, logic got_last);
      mark_t want;
      if (expected_marks.size() == 0) begin
        report_mismatch($sformatf("result with none expected: edge_mark=%0b frame_last=%0b",
                                  got_mark, got_last));
        return;
      end
      want = expected_marks.pop_front();
      if (got_mark !== want.edge_mark || got_last !== want.frame_last) begin
        report_mismatch($sformatf(
          "result %0d: expected edge_mark=%0b frame_last=%0b, got edge_mark=%0b frame_last=%0b",
          results_seen, want.edge_mark, want.frame_last, got_mark, got_last));
      end
      results_seen++;
    endfunction
  endclass

  // Every block input starts at a known value.
  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   pix_valid  = 1'b0;
  logic                   pix_stall;
  logic                   req_type   = REQ_PIXEL;
  logic [PIX_W-1:0]       pixel      = '0;
  logic                   res_valid;
  logic                   res_stall  = 1'b0;
  logic                   edge_mark;
  logic                   frame_last;

  mean_edge_scoreboard sb;
  reg_write_t          reg_plan [$];
  int unsigned         send_idle_pct = 15;
  int unsigned         recv_idle_pct = 49;
  int unsigned         useful_items  = 0;
  int unsigned         quiet_cycles  = 0;
  logic                progress;

  window_mean_edge_mark #(
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM)
  ) DUT (.*);

  always #(CLK_HALF) clk = ~clk;

  // The result side stalls at random with the current idle rate. The stall is registered at
  // the edge, so the monitor below always sees the value that held during the past cycle.
  always @(posedge clk) begin
    res_stall <= !rst && ($urandom_range(99) < recv_idle_pct);
  end

  // Results are checked at the edge where the handshake completes.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(edge_mark, frame_last);
  end

  // The watchdog ends a run that has stopped moving: no request, result or register write
  // while quiet_cycles counts up to QUIET_LIMIT.
  assign progress = (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
                    (cfg_valid && cfg_ready);

  always @(posedge clk) begin
    if (rst || progress) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request, with a random number of idle cycles ahead of it, and returns at the
  // edge where the block takes it. The scoreboard learns of it right there, in this process,
  // so later waits on the scoreboard never race the handshake.
  task automatic send_request(input logic kind, input logic [PIX_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    req_type  <= kind;
    pixel     <= value;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    sb.note_request(kind, value);
  endtask

  function automatic void plan_reg(input logic [CFG_INDEX_W-1:0] index,
                                   input logic [CFG_DATA_W-1:0] data);
    reg_write_t entry;
    entry.index = index;
    entry.data  = data;
    reg_plan = {reg_plan, entry};
  endfunction

  // Writes the planned registers back to back. Valid only drops once the list is empty.
  task automatic apply_regs();
    reg_write_t entry;
    while (reg_plan.size() != 0) begin
      entry = reg_plan.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= entry.index;
      cfg_data  <= entry.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.note_config(entry.index, entry.data);
    end
    cfg_valid <= 1'b0;
  endtask

  // Lets the block go idle: every expected result out, then the pipeline given time to empty
  // of requests that produce nothing (dropped flushes, a frame cut short).
  task automatic wait_idle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] fill_pixel(input fill_t fill, input int center);
    int v;
    case (fill)
      FILL_EXTREMES: return $urandom_range(1) ? 8'hFF : 8'h00;
      FILL_BAND: begin
        // Values close to one of the levels, so the mean lands on both sides of it.
        v = center + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[PIX_W-1:0];
      end
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_level_data();
    logic [LEVEL_W-1:0] level;
    int unsigned        r;
    r = $urandom_range(99);
    if (r < 10) level = '0;
    else if (r < 20) level = '1;
    else level = LEVEL_W'($urandom_range(255));
    // The bits above the level are don't-care in the block and are filled at random.
    return {3'($urandom_range(7)), level};
  endfunction

  // Sends one frame at the current size. A noisy frame sprinkles flushes before the frame
  // end (dropped) and drains partly with pixels (treated as flushes). A partial frame stops
  // early and leaves the restart to the next register write.
  task automatic run_frame(input fill_t fill, input bit noisy, input bit partial);
    int unsigned w, h, total, count;
    int          center;
    w = sb.active_width();
    h = sb.active_height();
    total = w * h;
    center = $urandom_range(1) ? int'(sb.black_reg) : int'(sb.white_reg);
    count = partial ? $urandom_range(total - 1) : total;
    for (int unsigned i = 0; i < count; i++) begin
      if (noisy && $urandom_range(99) < 5) send_request(REQ_FLUSH, PIX_W'($urandom_range(255)));
      send_request(REQ_PIXEL, fill_pixel(fill, center));
      useful_items++;
    end
    if (!partial) begin
      // The last result trails the last pixel by one row and one pixel.
      for (int unsigned i = 0; i <= w; i++) begin
        if (noisy && $urandom_range(99) < 20) begin
          send_request(REQ_PIXEL, PIX_W'($urandom_range(255)));
        end else begin
          send_request(REQ_FLUSH, PIX_W'($urandom_range(255)));
        end
        useful_items++;
      end
      // A flush after the frame is out produces nothing.
      if (noisy && $urandom_range(99) < 10) send_request(REQ_FLUSH, PIX_W'($urandom_range(255)));
    end
  endtask

  // New random frame size and levels. Most frames are a few pixels across, some a couple of
  // dozen wide and only a few rows high; zero sizes turn up and behave as one.
  task automatic plan_random_regs();
    logic [CFG_DATA_W-1:0] w, h;
    int unsigned           r;
    r = $urandom_range(99);
    if (r < 25) begin
      w = CFG_DATA_W'($urandom_range(9, 24));
      h = CFG_DATA_W'($urandom_range(4));
    end else begin
      w = CFG_DATA_W'($urandom_range(8));
      h = CFG_DATA_W'($urandom_range(8));
    end
    if ($urandom_range(1)) begin
      plan_reg(CFG_FRAME_WIDTH, w);
      plan_reg(CFG_FRAME_HEIGHT, h);
    end else begin
      plan_reg(CFG_FRAME_HEIGHT, h);
      plan_reg(CFG_FRAME_WIDTH, w);
    end
    if ($urandom_range(1)) plan_reg(CFG_WHITE_LEVEL, pick_level_data());
    if ($urandom_range(1)) plan_reg(CFG_BLACK_LEVEL, pick_level_data());
    if ($urandom_range(99) < 10) begin
      plan_reg(CFG_INDEX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
               CFG_DATA_W'($urandom_range(2047)));
    end
  endtask

  initial begin
    bit need_restart;
    fill_t fill;

    sb = new();
    need_restart = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a flush before any pixel is dropped.
    send_request(REQ_FLUSH, 8'h5A);
    wait_idle();

    // A 3 x 3 frame with fixed pixels and a flush in the middle of it. The drain mixes a
    // pixel in, and a flush after the last mark belongs to no frame.
    plan_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(3));
    plan_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(3));
    plan_reg(CFG_WHITE_LEVEL, CFG_DATA_W'(200));
    plan_reg(CFG_BLACK_LEVEL, CFG_DATA_W'(50));
    apply_regs();
    foreach (TILE_3X3[i]) begin
      if (i == 4) send_request(REQ_FLUSH, 8'hFF);
      send_request(REQ_PIXEL, TILE_3X3[i]);
    end
    send_request(REQ_FLUSH, 8'h00);
    send_request(REQ_PIXEL, 8'hFF);
    send_request(REQ_FLUSH, 8'hFF);
    send_request(REQ_FLUSH, 8'h00);
    send_request(REQ_FLUSH, 8'h77);

    // Same settings, next frame right away, black and white pixels only.
    run_frame(FILL_EXTREMES, 1'b0, 1'b0);
    wait_idle();

    // Zero sizes behave as one pixel; levels at the opposite extremes never mark. A write to
    // an index past the register list must change nothing.
    plan_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(0));
    plan_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(0));
    plan_reg(CFG_WHITE_LEVEL, CFG_DATA_W'(0));
    plan_reg(CFG_BLACK_LEVEL, 11'h7FF);
    plan_reg(CFG_UNUSED_LAST, 11'h7FF);
    apply_regs();
    run_frame(FILL_UNIFORM, 1'b0, 1'b0);
    run_frame(FILL_UNIFORM, 1'b0, 1'b0);
    wait_idle();

    // Full level range with pixels near black or near white, then black and white pixels only.
    plan_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(4));
    plan_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(3));
    plan_reg(CFG_WHITE_LEVEL, CFG_DATA_W'(255));
    plan_reg(CFG_BLACK_LEVEL, CFG_DATA_W'(0));
    apply_regs();
    run_frame(FILL_BAND, 1'b0, 1'b0);
    run_frame(FILL_EXTREMES, 1'b0, 1'b0);
    wait_idle();

    // A frame cut off partway, then a register write that starts a new one.
    plan_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(5));
    plan_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(4));
    apply_regs();
    repeat (13) send_request(REQ_PIXEL, PIX_W'($urandom_range(255)));
    wait_idle();
    plan_reg(CFG_BLACK_LEVEL, CFG_DATA_W'(100));
    apply_regs();
    run_frame(FILL_BAND, 1'b1, 1'b0);

    // Random frames. Most are complete and drained; some follow a register change made
    // while idle, and a few are cut short so that the next write has to restart them.
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      if (useful_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 49;
      end else if (useful_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (need_restart || $urandom_range(99) < 35) begin
        wait_idle();
        plan_random_regs();
        apply_regs();
        need_restart = 1'b0;
      end
      fill = fill_t'($urandom_range(2));
      if ($urandom_range(99) < 8) begin
        run_frame(fill, 1'b1, 1'b1);
        need_restart = 1'b1;
      end else begin
        run_frame(fill, 1'b1, 1'b0);
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
